// File: rtl/lad_pkg.sv
// shared types and codes for the linear array deque
package lad_pkg;

    // request codes
    typedef enum logic [1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_BACK   = 2'd2,
        REQ_POP_FRONT  = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    localparam int DATA_W = 32;

    // strobes from the control to the slot memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

// File: rtl/lad_mem.sv
// slot memory: one write port, one read port with registered data
module lad_mem
    import lad_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [DATA_W-1:0] o_rd_data
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port with registered data
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/lad_ctrl.sv
// mark tracking, request decode and result register
module lad_ctrl
    import lad_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int MW    = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  t_req                     i_req_type,
    input  logic signed [DATA_W-1:0] i_push_value,
    output t_mem_ctl                 o_mem_ctl,
    output logic [AW-1:0]            o_wr_addr,
    output logic signed [DATA_W-1:0] o_wr_data,
    output logic [AW-1:0]            o_rd_addr,
    input  logic signed [DATA_W-1:0] i_rd_data,
    output logic                     o_valid,
    output t_status                  o_status,
    output logic signed [DATA_W-1:0] o_pop_value,
    output logic                     o_is_full,
    output logic                     o_is_empty
);

    localparam logic [MW-1:0] TOP_MARK = MW'(DEPTH);
    localparam logic [MW-1:0] ONE      = MW'(1);

    logic [MW-1:0] r_front, n_front;
    logic [MW-1:0] r_back,  n_back;
    logic          r_valid;
    logic          r_pop_ok, n_pop_ok;
    t_status       r_status, n_status;
    logic          r_full, r_empty;
    logic          empty_now;
    logic [MW-1:0] wr_mark, rd_mark;

    assign empty_now = (r_front == r_back);

    // decode one transaction against the current marks
    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_status  = ST_DONE;
        n_pop_ok  = 1'b0;
        o_mem_ctl = '0;
        wr_mark   = r_back;
        rd_mark   = r_front;
        unique case (i_req_type)
            REQ_PUSH_BACK: begin
                wr_mark = r_back;
                if (r_back != TOP_MARK) begin
                    o_mem_ctl.wr_en = i_accept;
                    n_back          = r_back + ONE;
                end else begin
                    n_status = ST_NO_ROOM;
                end
            end
            REQ_PUSH_FRONT: begin
                wr_mark = r_front - ONE;
                if (r_front != '0) begin
                    o_mem_ctl.wr_en = i_accept;
                    n_front         = r_front - ONE;
                end else begin
                    n_status = ST_NO_ROOM;
                end
            end
            REQ_POP_BACK: begin
                rd_mark = r_back - ONE;
                if (!empty_now) begin
                    o_mem_ctl.rd_en = i_accept;
                    n_pop_ok        = 1'b1;
                    n_back          = r_back - ONE;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            REQ_POP_FRONT: begin
                rd_mark = r_front;
                if (!empty_now) begin
                    o_mem_ctl.rd_en = i_accept;
                    n_pop_ok        = 1'b1;
                    n_front         = r_front + ONE;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
                n_status = ST_EMPTY;
            end
        endcase
    end

    assign o_wr_addr = wr_mark[AW-1:0];
    assign o_rd_addr = rd_mark[AW-1:0];
    assign o_wr_data = i_push_value;

    // marks and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
            if (i_accept) begin
                r_front <= n_front;
                r_back  <= n_back;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
            r_full   <= (n_back == TOP_MARK);
            r_empty  <= (n_front == n_back);
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_pop_value = r_pop_ok ? i_rd_data : '0;
    assign o_is_full   = r_full;
    assign o_is_empty  = r_empty;

    // marks never cross and back never passes the top
    a_mark_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front <= r_back) && (r_back <= TOP_MARK))
        else $error("deque marks out of order");

    // every accepted transaction gives exactly one result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_valid)
        else $error("accepted transaction gave no result");

    // a refused request leaves both marks untouched
    a_refused_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (n_status != ST_DONE)) |=> ($stable(r_front) && $stable(r_back)))
        else $error("refused request moved a mark");

    // a memory access happens only on an accepted successful request
    a_mem_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_ctl.wr_en || o_mem_ctl.rd_en) |-> (i_accept && (n_status == ST_DONE)))
        else $error("slot access without a successful transaction");

endmodule

// File: rtl/linear_array_deque.sv
// top level of the linear array deque
// Linear (non-wrapping) double-ended queue of DEPTH signed 32-bit words held in a
// single-port-write, registered-read slot memory. A transaction is taken at a clock
// edge where start is high and busy is low; busy is high in reset and is cleared by the
// first clock edge after reset is released. One transaction can be taken every cycle
// while busy is low, and its result appears on the o_ ports, marked by o_valid, for
// exactly one cycle, in the cycle after it was taken, since reads are registered.
// Results cannot be stalled. Push front succeeds only into slots freed by front pops.
module linear_array_deque
    import lad_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_req_type,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_pop_value,
    output logic                     o_is_full,
    output logic                     o_is_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW = $clog2(DEPTH + 1);

    logic                     r_busy;
    logic                     accept;
    t_mem_ctl                 mem_ctl;
    logic [AW-1:0]            wr_addr, rd_addr;
    logic signed [DATA_W-1:0] wr_data, rd_data;
    t_status                  status;

    // busy holds off requests through reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    lad_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .MW    (MW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (t_req'(i_req_type)),
        .i_push_value (i_push_value),
        .o_mem_ctl    (mem_ctl),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_valid      (o_valid),
        .o_status     (status),
        .o_pop_value  (o_pop_value),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty)
    );

    lad_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_status = status;

endmodule

// File: tb/tb_linear_array_deque.sv
// self-checking testbench for the linear array deque
module tb_linear_array_deque;
    timeunit 1ns;
    timeprecision 1ps;
    import lad_pkg::*;

    localparam int DEPTH = 16;
    localparam int MAX_REPORTS = 10;

    // one expected result transaction
    typedef struct {
        t_status                 status;
        logic signed [DATA_W-1:0] pop_value;
        logic                    is_full;
        logic                    is_empty;
    } t_deque_result;

    // request mix used by the random part
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_FRONT_CHURN,
        MIX_UNIFORM
    } t_mix;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               i_req_type = '0;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_pop_value;
    logic                     o_is_full;
    logic                     o_is_empty;

    // shadow deque state
    logic signed [DATA_W-1:0] shadow_slots [DEPTH];
    int                       head_idx = 0;
    int                       tail_idx = 0;

    t_deque_result pending_results [$];
    int            err_count = 0;
    bit            idle_en = 1'b0;

    linear_array_deque #(.DEPTH(DEPTH)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty)
    );

    always #5 i_clk = ~i_clk;

    // apply one request to the shadow deque and return what the block should answer
    function automatic t_deque_result deque_apply(input t_req req,
                                                  input logic signed [DATA_W-1:0] value);
        t_deque_result res;
        bit            was_empty;
        was_empty     = (head_idx == tail_idx);
        res.status    = ST_DONE;
        res.pop_value = '0;
        case (req)
            REQ_PUSH_BACK: begin
                if (tail_idx < DEPTH) begin
                    shadow_slots[tail_idx] = value;
                    tail_idx++;
                end else begin
                    res.status = ST_NO_ROOM;
                end
            end
            REQ_PUSH_FRONT: begin
                if (head_idx > 0) begin
                    head_idx--;
                    shadow_slots[head_idx] = value;
                end else begin
                    res.status = ST_NO_ROOM;
                end
            end
            REQ_POP_BACK: begin
                if (!was_empty) begin
                    tail_idx--;
                    res.pop_value = shadow_slots[tail_idx];
                end else begin
                    res.status = ST_EMPTY;
                end
            end
            default: begin
                if (!was_empty) begin
                    res.pop_value = shadow_slots[head_idx];
                    head_idx++;
                end else begin
                    res.status = ST_EMPTY;
                end
            end
        endcase
        res.is_full  = (tail_idx == DEPTH);
        res.is_empty = (head_idx == tail_idx);
        return res;
    endfunction

    // send one request transaction, with an optional idle burst in front
    task automatic send_request(input t_req req, input logic signed [DATA_W-1:0] value);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= req;
        i_push_value <= value;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_results.push_back(deque_apply(req, value));
    endtask

    // push data: mostly full random words, sometimes the corners
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // pick a request type according to the current mix
    function automatic t_req pick_req(input t_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:        return (roll < 70) ? REQ_PUSH_BACK :
                                    (roll < 80) ? REQ_PUSH_FRONT :
                                    (roll < 90) ? REQ_POP_BACK : REQ_POP_FRONT;
            MIX_DRAIN:       return (roll < 15) ? REQ_PUSH_BACK :
                                    (roll < 25) ? REQ_PUSH_FRONT :
                                    (roll < 60) ? REQ_POP_BACK : REQ_POP_FRONT;
            MIX_FRONT_CHURN: return (roll < 15) ? REQ_PUSH_BACK :
                                    (roll < 55) ? REQ_PUSH_FRONT :
                                    (roll < 60) ? REQ_POP_BACK : REQ_POP_FRONT;
            default:         return t_req'(roll[1:0]);
        endcase
    endfunction

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_deque_result want;
        if (o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: result with no request pending: status %0d pop %0d",
                             $realtime, o_status, o_pop_value);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_pop_value !== want.pop_value ||
                    o_is_full !== want.is_full || o_is_empty !== want.is_empty) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch exp status %0d pop %0d full %0b empty %0b",
                                 $realtime, want.status, want.pop_value, want.is_full,
                                 want.is_empty);
                        $display("    got status %0d pop %0d full %0b empty %0b",
                                 o_status, o_pop_value, o_is_full, o_is_empty);
                    end
                end
            end
        end
    end

    // pops and a front push on the deque right after reset
    task automatic test_empty_refusals();
        send_request(REQ_POP_BACK, 32'sh1234_5678);
        send_request(REQ_POP_FRONT, -32'sd1);
        send_request(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
    endtask

    // fill from the back up to the top, then one push too many
    task automatic test_fill_to_top();
        logic signed [DATA_W-1:0] corners [6];
        corners = '{32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd0,
                    32'sh5555_5555, 32'shAAAA_AAAA};
        for (int i = 0; i < DEPTH; i++)
            send_request(REQ_PUSH_BACK, (i < 6) ? corners[i] : $urandom());
        send_request(REQ_PUSH_BACK, 32'sh0BAD_F00D);
    endtask

    // free slots at the front, refill them, hit the bottom, then pop from the back
    task automatic test_front_refill();
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_PUSH_FRONT, 32'sh8000_0000);
        send_request(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(REQ_PUSH_FRONT, 32'sh0000_0001);
        send_request(REQ_POP_BACK, '0);
    endtask

    // random request bursts, each with its own mix and idle setting
    task automatic test_random_mix(input int num_items, input bit allow_idle);
        int   sent;
        int   burst;
        t_mix mix;
        sent = 0;
        while (sent < num_items) begin
            mix     = t_mix'($urandom_range(0, 3));
            burst   = $urandom_range(8, 48);
            idle_en = allow_idle && ($urandom_range(0, 2) != 0);
            for (int i = 0; i < burst && sent < num_items; i++) begin
                send_request(pick_req(mix), pick_word());
                sent++;
            end
        end
        idle_en = 1'b0;
    endtask

    // main sequence
    initial begin
        int waited;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_en = 1'b1;
        test_empty_refusals();
        test_fill_to_top();
        test_front_refill();
        test_random_mix(1500, 1'b1);
        test_random_mix(200, 1'b0);
        start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 100) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            err_count++;
            $display("%0d expected results never arrived", pending_results.size());
        end

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
